/* sv/bpdb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and state codes for the frame power meter.
package bpdb_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WIN_W       = 13;
    localparam int MAX_WINDOW  = 4096;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SUM_W       = 42;
    localparam int CNT_W       = 13;
    localparam int DB_W        = 17;
    localparam int FRAC_W      = 16;
    localparam int EXP_W       = 6;
    localparam int LOG_W       = EXP_W + FRAC_W;
    localparam int MANT_W      = 31;
    localparam int DIFF_W      = LOG_W + 2;
    localparam int K_W         = 26;
    localparam int PROD_W      = LOG_W + K_W;
    localparam int ROUND_SH    = 32;
    localparam int Q_W         = PROD_W - ROUND_SH;
    localparam int IT_W        = 4;
    localparam int SQ_SHIFT    = 2 * SAMPLE_BITS - 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    localparam logic [WIN_W-1:0]       WIN_RESET   = WIN_W'(441);
    localparam logic [SUM_W-1:0]       SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [K_W-1:0]         DB_PER_LOG2 = K_W'(50504453);
    localparam logic [DIFF_W-1:0]      LOG_OFFSET  = DIFF_W'(SQ_SHIFT * (2 ** FRAC_W));
    localparam logic [PROD_W-1:0]      RND_HALF    = PROD_W'(1) << (ROUND_SH - 1);
    localparam logic signed [DB_W-1:0] SILENCE_DB  = -17'sd30720;
    localparam logic signed [DB_W-1:0] MIN_DB      = -17'sd33280;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_frame;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_DIFF,
        ST_MUL,
        ST_RND
    } t_state;

endpackage

/* sv/bpdb_front.sv */
`timescale 1ns / 1ps
// Front end: window register, sample squaring, frame accumulation and frame hand-off.
module bpdb_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [bpdb_pkg::WIN_W-1:0]             i_window_length,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [bpdb_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [bpdb_pkg::FIFO_CW-1:0]           i_fifo_cnt,
    output logic                                   o_push,
    output bpdb_pkg::t_frame                       o_frame
);

    logic [bpdb_pkg::WIN_W-1:0]       r_window;
    logic [bpdb_pkg::CNT_W-1:0]       r_count;
    logic [bpdb_pkg::SUM_W-1:0]       r_sum;
    logic                             r_s1_valid;
    logic                             r_s1_last;
    logic [bpdb_pkg::SQ_W-1:0]        r_s1_sq;
    logic [bpdb_pkg::CNT_W-1:0]       r_s1_cnt;

    logic [bpdb_pkg::WIN_W-1:0]       win_eff;
    logic [bpdb_pkg::CNT_W-1:0]       cnt_inc;
    logic                             last_now;
    logic                             pending;
    logic [bpdb_pkg::FIFO_CW:0]       slots;
    logic                             room;
    logic                             accept;
    logic [bpdb_pkg::SAMPLE_BITS-1:0] s_u;
    logic [bpdb_pkg::SAMPLE_BITS-1:0] mag;
    logic [bpdb_pkg::SQ_W-1:0]        sq;
    logic [bpdb_pkg::SUM_W:0]         acc;
    logic [bpdb_pkg::SUM_W-1:0]       sat;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_window == '0) begin
            win_eff = bpdb_pkg::WIN_W'(1);
        end else if (r_window > bpdb_pkg::WIN_W'(bpdb_pkg::MAX_WINDOW)) begin
            win_eff = bpdb_pkg::WIN_W'(bpdb_pkg::MAX_WINDOW);
        end else begin
            win_eff = r_window;
        end
    end

    assign cnt_inc  = r_count + 1'b1;
    assign last_now = bpdb_pkg::WIN_W'(cnt_inc) >= win_eff;
    assign pending  = r_s1_valid & r_s1_last;
    assign slots    = {1'b0, i_fifo_cnt} + (bpdb_pkg::FIFO_CW + 1)'(pending);
    assign room     = slots < (bpdb_pkg::FIFO_CW + 1)'(bpdb_pkg::FIFO_DEPTH);
    assign o_ready  = !last_now || room;
    assign accept   = i_valid && o_ready;

    assign s_u = i_sample;
    assign mag = s_u[bpdb_pkg::SAMPLE_BITS-1] ? (~s_u + 1'b1) : s_u;
    assign sq  = mag * mag;

    assign acc = {1'b0, r_sum} + (bpdb_pkg::SUM_W + 1)'(r_s1_sq);
    assign sat = acc[bpdb_pkg::SUM_W] ? bpdb_pkg::SUM_MAX : acc[bpdb_pkg::SUM_W-1:0];

    assign o_push        = r_s1_valid && r_s1_last;
    assign o_frame.sum   = sat;
    assign o_frame.count = r_s1_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= bpdb_pkg::WIN_RESET;
            r_count    <= '0;
            r_sum      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_window_length;
            end
            r_s1_valid <= accept;
            if (accept) begin
                r_count <= last_now ? '0 : cnt_inc;
            end
            if (r_s1_valid) begin
                r_sum <= r_s1_last ? '0 : sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sq   <= sq;
            r_s1_last <= last_now;
            r_s1_cnt  <= cnt_inc;
        end
    end

endmodule

/* sv/bpdb_fifo.sv */
`timescale 1ns / 1ps
// Short queue of finished frame totals between the front and back ends.
module bpdb_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bpdb_pkg::t_frame             i_frame,
    input  logic                         i_pop,
    output bpdb_pkg::t_frame             o_frame,
    output logic                         o_empty,
    output logic [bpdb_pkg::FIFO_CW-1:0] o_cnt
);

    bpdb_pkg::t_frame                 r_mem [bpdb_pkg::FIFO_DEPTH];
    logic [bpdb_pkg::FIFO_AW-1:0]     r_wr;
    logic [bpdb_pkg::FIFO_AW-1:0]     r_rd;
    logic [bpdb_pkg::FIFO_CW-1:0]     r_cnt;

    assign o_frame = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != bpdb_pkg::FIFO_CW'(bpdb_pkg::FIFO_DEPTH)))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("frame queue underflow");

endmodule

/* sv/bpdb_back.sv */
`timescale 1ns / 1ps
// Back end: iterative log2 of frame sum and count, dB scaling and output register.
module bpdb_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  bpdb_pkg::t_frame                    i_frame,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bpdb_pkg::DB_W-1:0]    o_power_db
);

    bpdb_pkg::t_state                  r_state;
    bpdb_pkg::t_state                  n_state;
    logic [bpdb_pkg::SUM_W-1:0]        r_norm;
    logic [bpdb_pkg::EXP_W-1:0]        r_exp;
    logic [bpdb_pkg::MANT_W-1:0]       r_m;
    logic [bpdb_pkg::FRAC_W-1:0]       r_frac;
    logic [bpdb_pkg::IT_W-1:0]         r_it;
    logic                              r_pass;
    logic                              r_silent;
    logic [bpdb_pkg::CNT_W-1:0]        r_cnt;
    logic [bpdb_pkg::LOG_W-1:0]        r_log_sum;
    logic [bpdb_pkg::LOG_W-1:0]        r_mag;
    logic [bpdb_pkg::PROD_W-1:0]       r_prod;
    logic                              r_out_valid;
    logic signed [bpdb_pkg::DB_W-1:0]  r_out_db;

    logic                              out_free;
    logic                              out_load;
    logic                              top_zero;
    logic                              top_set;
    logic [2*bpdb_pkg::MANT_W-1:0]     sq_prod;
    logic [bpdb_pkg::MANT_W:0]         sq_top;
    logic                              sq_bit;
    logic [bpdb_pkg::MANT_W-1:0]       m_next;
    logic [bpdb_pkg::FRAC_W-1:0]       frac_next;
    logic                              sq_done;
    logic [bpdb_pkg::DIFF_W-1:0]       diff;
    logic [bpdb_pkg::DIFF_W-1:0]       diff_neg;
    logic [bpdb_pkg::LOG_W-1:0]        mag;
    logic [bpdb_pkg::PROD_W-1:0]       rnd;
    logic [bpdb_pkg::Q_W-1:0]          q;
    logic signed [bpdb_pkg::DB_W-1:0]  res_raw;
    logic signed [bpdb_pkg::DB_W-1:0]  result;

    assign out_free = !r_out_valid || i_ready;
    assign top_zero = (r_norm[bpdb_pkg::SUM_W-1 -: 4] == 4'd0);
    assign top_set  = r_norm[bpdb_pkg::SUM_W-1];

    // one squaring step of the log2 mantissa
    assign sq_prod   = r_m * r_m;
    assign sq_top    = sq_prod[2*bpdb_pkg::MANT_W-1:bpdb_pkg::MANT_W-1];
    assign sq_bit    = sq_top[bpdb_pkg::MANT_W];
    assign m_next    = sq_bit ? sq_top[bpdb_pkg::MANT_W:1] : sq_top[bpdb_pkg::MANT_W-1:0];
    assign frac_next = {r_frac[bpdb_pkg::FRAC_W-2:0], sq_bit};
    assign sq_done   = (r_it == bpdb_pkg::IT_W'(bpdb_pkg::FRAC_W - 1));

    // log2(sum) - log2(count) - offset, clamped at zero, magnitude kept
    assign diff     = {2'b00, r_log_sum} - {2'b00, r_exp, r_frac} - bpdb_pkg::LOG_OFFSET;
    assign diff_neg = ~diff + 1'b1;
    assign mag      = diff[bpdb_pkg::DIFF_W-1] ? diff_neg[bpdb_pkg::LOG_W-1:0] : '0;

    assign rnd     = r_prod + bpdb_pkg::RND_HALF;
    assign q       = rnd[bpdb_pkg::PROD_W-1:bpdb_pkg::ROUND_SH];
    assign res_raw = -$signed(bpdb_pkg::DB_W'(q));

    always_comb begin
        if (r_silent) begin
            result = bpdb_pkg::SILENCE_DB;
        end else if (res_raw < bpdb_pkg::MIN_DB) begin
            result = bpdb_pkg::MIN_DB;
        end else begin
            result = res_raw;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpdb_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_frame.sum == '0) ? bpdb_pkg::ST_RND : bpdb_pkg::ST_NORM;
                end
            end
            bpdb_pkg::ST_NORM: begin
                if (top_set) begin
                    n_state = bpdb_pkg::ST_SQR;
                end
            end
            bpdb_pkg::ST_SQR: begin
                if (sq_done) begin
                    n_state = r_pass ? bpdb_pkg::ST_DIFF : bpdb_pkg::ST_NORM;
                end
            end
            bpdb_pkg::ST_DIFF: n_state = bpdb_pkg::ST_MUL;
            bpdb_pkg::ST_MUL:  n_state = bpdb_pkg::ST_RND;
            bpdb_pkg::ST_RND: begin
                if (out_free) begin
                    n_state = bpdb_pkg::ST_IDLE;
                end
            end
            default: n_state = bpdb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            bpdb_pkg::ST_IDLE: o_pop    = !i_empty;
            bpdb_pkg::ST_RND:  out_load = out_free;
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpdb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_db <= result;
        end
        unique case (r_state)
            bpdb_pkg::ST_IDLE: begin
                if (o_pop) begin
                    r_norm   <= i_frame.sum;
                    r_cnt    <= i_frame.count;
                    r_exp    <= bpdb_pkg::EXP_W'(bpdb_pkg::SUM_W - 1);
                    r_pass   <= 1'b0;
                    r_silent <= (i_frame.sum == '0);
                end
            end
            bpdb_pkg::ST_NORM: begin
                if (top_zero) begin
                    r_norm <= r_norm << 4;
                    r_exp  <= r_exp - bpdb_pkg::EXP_W'(4);
                end else if (!top_set) begin
                    r_norm <= r_norm << 1;
                    r_exp  <= r_exp - 1'b1;
                end else begin
                    r_m    <= r_norm[bpdb_pkg::SUM_W-1 -: bpdb_pkg::MANT_W];
                    r_frac <= '0;
                    r_it   <= '0;
                end
            end
            bpdb_pkg::ST_SQR: begin
                r_m    <= m_next;
                r_frac <= frac_next;
                r_it   <= r_it + 1'b1;
                if (sq_done && !r_pass) begin
                    r_log_sum <= {r_exp, frac_next};
                    r_norm    <= bpdb_pkg::SUM_W'(r_cnt);
                    r_exp     <= bpdb_pkg::EXP_W'(bpdb_pkg::SUM_W - 1);
                    r_pass    <= 1'b1;
                end
            end
            bpdb_pkg::ST_DIFF: r_mag  <= mag;
            bpdb_pkg::ST_MUL:  r_prod <= bpdb_pkg::PROD_W'(r_mag * bpdb_pkg::DB_PER_LOG2);
            bpdb_pkg::ST_RND:  r_prod <= r_prod;
            default:           r_prod <= r_prod;
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_power_db = r_out_db;

    a_db_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_db <= 0) && (r_out_db >= bpdb_pkg::MIN_DB))
        else $error("power_db out of range");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == bpdb_pkg::ST_NORM) || (r_state == bpdb_pkg::ST_RND))
        else $error("frame popped without starting work");

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpdb_pkg::ST_NORM) |-> (r_norm != '0))
        else $error("normalising a zero value");

endmodule

/* sv/block_power_db_meter_unit.sv */
`timescale 1ns / 1ps
// Top level of the frame power meter: front end, frame queue and log back end.
//
// Usage:
//   Samples arrive on i_valid / o_ready / i_sample, one word per cycle at most.
//   Each frame of window_length samples (0 acts as 1, above 4096 as 4096)
//   yields one word on o_valid / i_ready / o_power_db: mean power in 1/256 dB,
//   -30720 for an all-zero frame. The user must write the window register
//   through i_cfg_valid / o_cfg_ready / i_window_length only while the
//   block is idle, unenforced by the block itself; o_cfg_ready is always high.
// Result path: a frame's result passes the accumulate register and the queue,
//   then per log2 operand a shift normaliser (plus a load step) and sixteen
//   squaring steps, then the scaling states ST_DIFF, ST_MUL and ST_RND; an
//   all-zero frame goes from the queue straight to ST_RND.
// Throughput: one sample per cycle while o_ready is high; the back end works
//   on one frame at a time, so short frames fill the four-entry queue and
//   o_ready drops on a frame-ending sample until a slot frees.
// Reset: clears the accumulator, sample count, queue and back end; window
//   returns to 441. A stalled result is held in the output register while the
//   back end works on the next frame.
module block_power_db_meter_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bpdb_pkg::WIN_W-1:0]              i_window_length,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [bpdb_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [bpdb_pkg::DB_W-1:0]        o_power_db
);

    logic                          push;
    logic                          pop;
    logic                          empty;
    logic [bpdb_pkg::FIFO_CW-1:0]  fifo_cnt;
    bpdb_pkg::t_frame              frame_in;
    bpdb_pkg::t_frame              frame_out;

    bpdb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_window_length (i_window_length),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_fifo_cnt      (fifo_cnt),
        .o_push          (push),
        .o_frame         (frame_in)
    );

    bpdb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (frame_in),
        .i_pop   (pop),
        .o_frame (frame_out),
        .o_empty (empty),
        .o_cnt   (fifo_cnt)
    );

    bpdb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_frame    (frame_out),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_power_db (o_power_db)
    );

endmodule

/* tb/sv/tb_block_power_db_meter_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the frame power meter: sample stream, window changes, stalls.
module tb_block_power_db_meter_unit;

    localparam int HALF_PERIOD   = 5;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int IDLE_PCT      = 28;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 800;
    localparam int HOLD_PHASE    = 6;
    localparam int LOUD_WORDS    = 256;

    typedef enum int {
        SRC_RANDOM,
        SRC_QUIET,
        SRC_SILENT,
        SRC_FULL,
        SRC_SPIKY
    } t_src;

    logic                                    i_clk           = 1'b0;
    logic                                    i_rst_n         = 1'b0;
    logic                                    i_cfg_valid     = 1'b0;
    logic                                    o_cfg_ready;
    logic [bpdb_pkg::WIN_W-1:0]              i_window_length = '0;
    logic                                    i_valid         = 1'b0;
    logic                                    o_ready;
    logic signed [bpdb_pkg::SAMPLE_BITS-1:0] i_sample        = '0;
    logic                                    o_valid;
    logic                                    i_ready         = 1'b0;
    logic signed [bpdb_pkg::DB_W-1:0]        o_power_db;

    logic signed [bpdb_pkg::SAMPLE_BITS-1:0] sample_q[$];
    logic signed [bpdb_pkg::DB_W-1:0]        pending_db[$];
    logic signed [bpdb_pkg::DB_W-1:0]        want_db;
    logic [bpdb_pkg::WIN_W-1:0]              win_shadow = bpdb_pkg::WIN_RESET;
    logic [63:0]                             acc_energy = '0;
    int unsigned                             acc_count  = 0;

    int n_accepted = 0;
    int n_errors   = 0;
    int cycles     = 0;
    int hold_at    = 0;
    int hold_left  = 0;
    bit no_gaps    = 1'b0;
    bit hold_armed = 1'b0;
    bit hold_done  = 1'b0;

    block_power_db_meter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_window_length (i_window_length),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_power_db      (o_power_db)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void queue_sample(input logic signed [bpdb_pkg::SAMPLE_BITS-1:0] s);
        sample_q.insert(sample_q.size(), s);
    endfunction

    function automatic void queue_result(input logic signed [bpdb_pkg::DB_W-1:0] db);
        pending_db.insert(pending_db.size(), db);
    endfunction

    // log2 in Q16: leading-one position, then fraction bits by repeated squaring
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        if (e >= 30)
            m = x >> (e - 30);
        else
            m = x << (30 - e);
        frac = '0;
        for (int i = 0; i < bpdb_pkg::FRAC_W; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << bpdb_pkg::FRAC_W) | frac;
    endfunction

    function automatic logic signed [bpdb_pkg::DB_W-1:0] frame_power_db(
        input logic [63:0] sum, input int unsigned count);
        longint      d;
        logic [63:0] q;
        longint      r;
        if (sum == 0 || count == 0)
            return bpdb_pkg::SILENCE_DB;
        d = longint'(log2_fixed(sum)) - longint'(log2_fixed(64'(count)))
            - (longint'(bpdb_pkg::SQ_SHIFT) << bpdb_pkg::FRAC_W);
        if (d > 0)
            d = 0;
        q = (64'(-d) * 64'(bpdb_pkg::DB_PER_LOG2) + (64'd1 << 31)) >> 32;
        r = -longint'(q);
        if (r < bpdb_pkg::MIN_DB)
            r = bpdb_pkg::MIN_DB;
        return bpdb_pkg::DB_W'(r);
    endfunction

    function automatic void accumulate_sample(
        input logic signed [bpdb_pkg::SAMPLE_BITS-1:0] s);
        logic [bpdb_pkg::SAMPLE_BITS:0] mag;
        int unsigned                    win;
        if (s[bpdb_pkg::SAMPLE_BITS-1])
            mag = ((bpdb_pkg::SAMPLE_BITS + 1)'(1) << bpdb_pkg::SAMPLE_BITS) - {1'b0, s};
        else
            mag = {1'b0, s};
        acc_energy = acc_energy + 64'(mag) * 64'(mag);
        if (acc_energy > 64'(bpdb_pkg::SUM_MAX))
            acc_energy = 64'(bpdb_pkg::SUM_MAX);
        acc_count++;
        win = 32'(win_shadow);
        if (win == 0)
            win = 1;
        if (win > 32'(bpdb_pkg::MAX_WINDOW))
            win = 32'(bpdb_pkg::MAX_WINDOW);
        if (acc_count >= win) begin
            queue_result(frame_power_db(acc_energy, acc_count));
            acc_energy = '0;
            acc_count  = 0;
        end
    endfunction

    function automatic logic signed [bpdb_pkg::SAMPLE_BITS-1:0] gen_sample(input t_src src);
        case (src)
            SRC_QUIET: begin
                return bpdb_pkg::SAMPLE_BITS'(int'($urandom_range(16)) - 8);
            end
            SRC_SILENT: begin
                return '0;
            end
            SRC_FULL: begin
                case ($urandom_range(3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh8001;
                    default: return 16'sh0001;
                endcase
            end
            SRC_SPIKY: begin
                return ($urandom_range(15) == 0) ? bpdb_pkg::SAMPLE_BITS'($urandom) : '0;
            end
            default: begin
                return bpdb_pkg::SAMPLE_BITS'($urandom);
            end
        endcase
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                accumulate_sample(i_sample);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                    i_valid  <= 1'b1;
                    i_sample <= sample_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready generation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_db.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected word: power_db %0d", o_power_db);
                end else begin
                    want_db = pending_db.pop_front();
                    if (o_power_db !== want_db) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("power_db mismatch: expected %0d, got %0d",
                                     want_db, o_power_db);
                    end
                end
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_armed && !hold_done && n_accepted >= hold_at) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic settle();
        while (sample_q.size() != 0 || i_valid || pending_db.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [bpdb_pkg::WIN_W-1:0] w);
        i_cfg_valid     <= 1'b1;
        i_window_length <= w;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        win_shadow = w;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic feed(input t_src src, input int n);
        repeat (n) queue_sample(gen_sample(src));
    endtask

    initial begin
        int                         n_random;
        int                         phase;
        int                         len;
        logic [bpdb_pkg::WIN_W-1:0] win;
        t_src                       src;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-sample frames: silence, full scale, smallest step, alternating bits
        write_window(bpdb_pkg::WIN_W'(1));
        queue_sample(16'sh0000);
        queue_sample(16'sh7FFF);
        queue_sample(16'sh8000);
        queue_sample(16'sh8001);
        queue_sample(16'sh0001);
        queue_sample(16'shFFFF);
        queue_sample(16'sh5555);
        queue_sample(16'shAAAA);
        settle();
        write_window(bpdb_pkg::WIN_W'(0));
        queue_sample(16'sd100);
        queue_sample(-16'sd100);
        settle();
        write_window(bpdb_pkg::WIN_W'(3));
        queue_sample(16'sh0000);
        queue_sample(16'sh0000);
        queue_sample(16'sh0000);
        queue_sample(16'sh8000);
        queue_sample(16'sh0000);
        queue_sample(16'sh0001);
        settle();
        // partial frames carried across window changes
        write_window('1);
        feed(SRC_RANDOM, 3);
        settle();
        write_window(bpdb_pkg::WIN_W'(2));
        feed(SRC_RANDOM, 1);
        settle();
        write_window(bpdb_pkg::WIN_W'(bpdb_pkg::MAX_WINDOW));
        feed(SRC_QUIET, 2);
        settle();
        write_window(bpdb_pkg::WIN_W'(bpdb_pkg::MAX_WINDOW + 1));
        feed(SRC_RANDOM, 2);
        settle();
        write_window(bpdb_pkg::WIN_W'(1));
        feed(SRC_FULL, 1);
        settle();

        n_random = 0;
        phase    = 0;
        while (n_random < RANDOM_WORDS || phase <= HOLD_PHASE) begin
            case ($urandom_range(19))
                0:       win = bpdb_pkg::WIN_W'(0);
                1:       win = bpdb_pkg::WIN_W'(1);
                2:       win = '1;
                3:       win = bpdb_pkg::WIN_W'(bpdb_pkg::MAX_WINDOW);
                4, 5:    win = bpdb_pkg::WIN_W'($urandom_range(300, 25));
                default: win = bpdb_pkg::WIN_W'($urandom_range(24, 2));
            endcase
            len     = $urandom_range(120, 30);
            src     = t_src'($urandom_range(SRC_SPIKY));
            no_gaps = (phase == 3);
            if (phase == 3)
                len = 300;
            if (phase == HOLD_PHASE) begin
                win        = bpdb_pkg::WIN_W'(1);
                len        = 200;
                src        = SRC_RANDOM;
                hold_at    = n_accepted + 20;
                hold_armed = 1'b1;
            end
            write_window(win);
            feed(src, len);
            settle();
            n_random += len;
            phase++;
        end
        no_gaps = 1'b0;

        // close any open frame, then a frame of negative full scale for the loudest mean
        write_window(bpdb_pkg::WIN_W'(1));
        queue_sample(16'sh0000);
        settle();
        write_window(bpdb_pkg::WIN_W'(LOUD_WORDS));
        repeat (LOUD_WORDS) queue_sample(16'sh8000);
        settle();

        if (n_errors == 0 && pending_db.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/bpdb_pkg.sv
sv/bpdb_front.sv
sv/bpdb_fifo.sv
sv/bpdb_back.sv
sv/block_power_db_meter_unit.sv
tb/sv/tb_block_power_db_meter_unit.sv
